// ===== sv/stepper_homing_sweep_sequencer_assert.svh =====
`ifndef STEPPER_HOMING_SWEEP_SEQUENCER_ASSERT_SVH
`define STEPPER_HOMING_SWEEP_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHS_ASSERT_SAME(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("shs check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHS_ASSERT_NEXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("shs check failed");

`endif

// ===== sv/shs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

  localparam int HALF_PERIOD_BITS_DEF = 16;
  localparam int CFG_HALF_W           = 16;
  localparam int GROUP_W              = 4;
  localparam int PULSE_W              = 12;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 16;
  localparam int PHASE_W              = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HOME_HALF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HALF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_GROUP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PULSE = 3'd4;

  localparam logic [CFG_HALF_W-1:0] HOME_HALF_RST   = 16'd1000;
  localparam logic [CFG_HALF_W-1:0] SWEEP_HALF_RST  = 16'd1000;
  localparam logic [GROUP_W-1:0]    SEEK_GROUP_RST  = 4'd5;
  localparam logic [PULSE_W-1:0]    OFFSET_RST      = 12'd1200;
  localparam logic [PULSE_W-1:0]    SWEEP_PULSE_RST = 12'd2700;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEEK   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_OFFSET = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SWREV  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SWFWD  = 3'd4;

endpackage
`default_nettype wire

// ===== sv/shs_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface shs_in_if;
  logic valid;
  logic ready;
  logic home_sensor;
  logic start_home;
  logic start_sweep;
  modport source (output valid, output home_sensor, output start_home,
                  output start_sweep, input ready);
  modport sink (input valid, input home_sensor, input start_home,
                input start_sweep, output ready);
endinterface

interface shs_out_if;
  logic valid;
  logic ready;
  logic step_level;
  logic direction;
  logic busy_res;
  logic homed;
  modport source (output valid, output step_level, output direction,
                  output busy_res, output homed, input ready);
  modport sink (input valid, input step_level, input direction,
                input busy_res, input homed, output ready);
endinterface

interface shs_cfg_if;
  import shs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/stepper_homing_sweep_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// stepper homing and sweep sequencer
// in_ch: one item per 1 us tick carrying the home sensor level and the
//   start_home / start_sweep requests
// out_ch: one result item per input item with step level, direction, busy
//   and homed, all as they stand after that tick
// cfg_ch: register writes (index 0..4: home half period, sweep half period,
//   seek group size, offset pulses, sweep pulses), always ready, one per cycle;
//   unknown indexes are dropped
// latency: the result of an item is valid in the cycle after it is taken
// throughput: one item per cycle; the sequencer state and the result register
//   are updated in the same edge, so a new tick is taken every cycle while the
//   result register is empty or being drained
// receiver stall: while a result waits with out_ch.ready low, in_ch.ready is
//   low and the state holds
// reset: idle, not homed, step line high, direction forward, registers at
//   their default values, no result pending
module stepper_homing_sweep_sequencer #(
  parameter int HALF_PERIOD_BITS = shs_pkg::HALF_PERIOD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  shs_in_if.sink     in_ch,
  shs_out_if.source  out_ch,
  shs_cfg_if.sink    cfg_ch
);
  import shs_pkg::*;

  localparam int HW = (HALF_PERIOD_BITS < CFG_HALF_W) ? HALF_PERIOD_BITS : CFG_HALF_W;
  localparam int TW = (HALF_PERIOD_BITS > CFG_HALF_W) ? HALF_PERIOD_BITS : CFG_HALF_W;
  localparam logic [CFG_HALF_W-1:0] HALF_MASK = {CFG_HALF_W{1'b1}} >> (CFG_HALF_W - HW);

  logic [CFG_HALF_W-1:0] home_half_r, sweep_half_r;
  logic [GROUP_W-1:0]    seek_group_r;
  logic [PULSE_W-1:0]    offset_r, sweep_pulse_r;

  logic [PHASE_W-1:0]          phase_r, phase_nxt;
  logic                        done_r, done_nxt;
  logic                        seek_r, seek_nxt;
  logic [PULSE_W-1:0]          pulse_r, pulse_nxt;
  logic [GROUP_W-1:0]          group_r, group_nxt;
  logic [HALF_PERIOD_BITS-1:0] tick_r, tick_nxt;
  logic                        step_r, step_nxt;
  logic                        dir_r, dir_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        in_fire;
  logic [CFG_HALF_W-1:0]       half_raw;
  logic [TW-1:0]               half;
  logic [GROUP_W-1:0]          grp, group_inc;
  logic [PULSE_W-1:0]          pulse_inc;
  logic                        offset_go;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_level = step_r;
  assign out_ch.direction  = dir_r;
  assign out_ch.busy_res   = (phase_r != PH_IDLE);
  assign out_ch.homed      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_half_r   <= HOME_HALF_RST;
      sweep_half_r  <= SWEEP_HALF_RST;
      seek_group_r  <= SEEK_GROUP_RST;
      offset_r      <= OFFSET_RST;
      sweep_pulse_r <= SWEEP_PULSE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_HOME_HALF:   home_half_r   <= cfg_ch.data[CFG_HALF_W-1:0] & HALF_MASK;
        REG_SWEEP_HALF:  sweep_half_r  <= cfg_ch.data[CFG_HALF_W-1:0] & HALF_MASK;
        REG_SEEK_GROUP:  seek_group_r  <= cfg_ch.data[GROUP_W-1:0];
        REG_OFFSET:      offset_r      <= cfg_ch.data[PULSE_W-1:0];
        REG_SWEEP_PULSE: sweep_pulse_r <= cfg_ch.data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign half_raw  = (phase_r == PH_SWREV || phase_r == PH_SWFWD) ? sweep_half_r : home_half_r;
  assign half      = (half_raw == '0) ? TW'(1) : TW'(half_raw);
  assign grp       = (seek_group_r == '0) ? GROUP_W'(1) : seek_group_r;
  assign group_inc = group_r + GROUP_W'(1);
  assign pulse_inc = pulse_r + PULSE_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = done_r;
    seek_nxt  = seek_r;
    pulse_nxt = pulse_r;
    group_nxt = group_r;
    tick_nxt  = tick_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    offset_go = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (in_ch.start_home && !done_r) begin
        seek_nxt  = in_ch.home_sensor;
        dir_nxt   = !in_ch.home_sensor;
        phase_nxt = PH_SEEK;
        group_nxt = '0;
        pulse_nxt = '0;
        step_nxt  = 1'b0;
        tick_nxt  = HALF_PERIOD_BITS'(1);
      end else if (in_ch.start_sweep && sweep_pulse_r != '0) begin
        phase_nxt = PH_SWREV;
        dir_nxt   = 1'b1;
        pulse_nxt = '0;
        step_nxt  = 1'b0;
        tick_nxt  = HALF_PERIOD_BITS'(1);
      end
    end else if (TW'(tick_r) < half) begin
      tick_nxt = tick_r + HALF_PERIOD_BITS'(1);
    end else if (!step_r) begin
      step_nxt = 1'b1;
      tick_nxt = HALF_PERIOD_BITS'(1);
    end else begin
      // end of one full pulse
      step_nxt = 1'b0;
      tick_nxt = HALF_PERIOD_BITS'(1);
      unique case (phase_r)
        PH_SEEK: begin
          if (group_inc >= grp) begin
            group_nxt = '0;
            offset_go = (in_ch.home_sensor != seek_r);
          end else begin
            group_nxt = group_inc;
          end
          if (offset_go) begin
            if (offset_r == '0) begin
              done_nxt  = 1'b1;
              phase_nxt = PH_IDLE;
              step_nxt  = 1'b1;
              tick_nxt  = '0;
            end else begin
              phase_nxt = PH_OFFSET;
              dir_nxt   = 1'b0;
              pulse_nxt = '0;
            end
          end
        end
        PH_OFFSET: begin
          pulse_nxt = pulse_inc;
          if (pulse_inc >= offset_r) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
            step_nxt  = 1'b1;
            tick_nxt  = '0;
          end
        end
        PH_SWREV: begin
          if (pulse_inc >= sweep_pulse_r) begin
            phase_nxt = PH_SWFWD;
            dir_nxt   = 1'b0;
            pulse_nxt = '0;
          end else begin
            pulse_nxt = pulse_inc;
          end
        end
        PH_SWFWD: begin
          pulse_nxt = pulse_inc;
          if (pulse_inc >= sweep_pulse_r) begin
            phase_nxt = PH_IDLE;
            step_nxt  = 1'b1;
            tick_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          step_nxt  = 1'b1;
          tick_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      done_r      <= 1'b0;
      seek_r      <= 1'b0;
      pulse_r     <= '0;
      group_r     <= '0;
      tick_r      <= '0;
      step_r      <= 1'b1;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        done_r  <= done_nxt;
        seek_r  <= seek_nxt;
        pulse_r <= pulse_nxt;
        group_r <= group_nxt;
        tick_r  <= tick_nxt;
        step_r  <= step_nxt;
        dir_r   <= dir_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/shs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_homing_sweep_sequencer_assert.svh"
module shs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_step_level,
  input wire logic out_direction,
  input wire logic out_busy_res,
  input wire logic out_homed
);
  // idle means the step line rests high
  `SHS_ASSERT_SAME(a_idle_step_high, out_valid && !out_busy_res, out_step_level)
  // an empty result register never blocks the input
  `SHS_ASSERT_SAME(a_empty_takes_input, !out_valid, in_ready)
  `SHS_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
  `SHS_ASSERT_NEXT(a_out_payload_holds, out_valid && !out_ready,
    $stable({out_step_level, out_direction, out_busy_res, out_homed}))
endmodule

bind stepper_homing_sweep_sequencer shs_checker u_shs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_step_level (out_ch.step_level),
  .out_direction  (out_ch.direction),
  .out_busy_res   (out_ch.busy_res),
  .out_homed      (out_ch.homed)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import shs_pkg::*;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_BASE = 3'd5;

  typedef struct packed {
    logic home_sensor;
    logic start_home;
    logic start_sweep;
  } tick_t;

  typedef struct packed {
    logic step_level;
    logic direction;
    logic busy;
    logic homed;
  } drive_t;

  logic clk;
  logic rst_n;

  shs_in_if  in_ch();
  shs_out_if out_ch();
  shs_cfg_if cfg_ch();

  stepper_homing_sweep_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // register copies
  logic [CFG_HALF_W-1:0] home_half_q  = HOME_HALF_RST;
  logic [CFG_HALF_W-1:0] sweep_half_q = SWEEP_HALF_RST;
  logic [GROUP_W-1:0]    seek_group_q = SEEK_GROUP_RST;
  logic [PULSE_W-1:0]    offset_q     = OFFSET_RST;
  logic [PULSE_W-1:0]    sweep_len_q  = SWEEP_PULSE_RST;

  // sequencer state copy
  logic [PHASE_W-1:0]    motor_phase      = PH_IDLE;
  logic                  motor_homed      = 1'b0;
  logic                  motor_seek_level = 1'b0;
  logic [PULSE_W-1:0]    motor_pulses     = '0;
  logic [GROUP_W-1:0]    motor_group      = '0;
  logic [CFG_HALF_W-1:0] motor_ticks      = '0;
  logic                  motor_step       = 1'b1;
  logic                  motor_dir        = DIR_FWD;

  tick_t  tick_queue[$];
  drive_t expected_drive[$];
  int     ticks_pushed = 0;
  int     ticks_taken = 0;
  int     error_count = 0;
  bit     in_calm = 1'b0;
  bit     out_calm = 1'b0;

  task automatic report_mismatch(input string msg);
    if (error_count < 50)
      $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int next_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function void start_low_half();
    motor_step = 1'b0;
    motor_ticks = CFG_HALF_W'(1);
  endfunction

  function void go_quiet();
    motor_phase = PH_IDLE;
    motor_step = 1'b1;
    motor_ticks = '0;
  endfunction

  task automatic motor_tick(input tick_t t);
    logic [CFG_HALF_W-1:0] half;
    logic [GROUP_W-1:0]    need;
    logic                  changed;
    if (motor_phase == PH_IDLE) begin
      if (t.start_home && !motor_homed) begin
        motor_seek_level = t.home_sensor;
        motor_dir = t.home_sensor ? DIR_FWD : DIR_REV;
        motor_phase = PH_SEEK;
        motor_group = '0;
        motor_pulses = '0;
        start_low_half();
      end else if (t.start_sweep && sweep_len_q != '0) begin
        motor_phase = PH_SWREV;
        motor_dir = DIR_REV;
        motor_pulses = '0;
        start_low_half();
      end
    end else begin
      half = (motor_phase == PH_SWREV || motor_phase == PH_SWFWD) ? sweep_half_q : home_half_q;
      if (half == '0)
        half = CFG_HALF_W'(1);
      if (motor_ticks < half) begin
        motor_ticks = motor_ticks + 1'b1;
      end else if (!motor_step) begin
        motor_step = 1'b1;
        motor_ticks = CFG_HALF_W'(1);
      end else begin
        case (motor_phase)
          PH_SEEK: begin
            need = (seek_group_q == '0) ? GROUP_W'(1) : seek_group_q;
            motor_group = motor_group + 1'b1;
            changed = 1'b0;
            if (motor_group >= need) begin
              motor_group = '0;
              changed = (t.home_sensor != motor_seek_level);
            end
            if (!changed) begin
              start_low_half();
            end else if (offset_q == '0) begin
              motor_homed = 1'b1;
              go_quiet();
            end else begin
              motor_phase = PH_OFFSET;
              motor_dir = DIR_FWD;
              motor_pulses = '0;
              start_low_half();
            end
          end
          PH_OFFSET: begin
            motor_pulses = motor_pulses + 1'b1;
            if (motor_pulses >= offset_q) begin
              motor_homed = 1'b1;
              go_quiet();
            end else begin
              start_low_half();
            end
          end
          PH_SWREV: begin
            motor_pulses = motor_pulses + 1'b1;
            if (motor_pulses >= sweep_len_q) begin
              motor_phase = PH_SWFWD;
              motor_dir = DIR_FWD;
              motor_pulses = '0;
            end
            start_low_half();
          end
          PH_SWFWD: begin
            motor_pulses = motor_pulses + 1'b1;
            if (motor_pulses >= sweep_len_q)
              go_quiet();
            else
              start_low_half();
          end
          default: go_quiet();
        endcase
      end
    end
  endtask

  // tick driver
  tick_t cur_tick;
  int    in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        motor_tick(cur_tick);
        ticks_taken++;
        expected_drive.push_back({motor_step, motor_dir, motor_phase != PH_IDLE, motor_homed});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          cur_tick = tick_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.home_sensor <= cur_tick.home_sensor;
          in_ch.start_home <= cur_tick.start_home;
          in_ch.start_sweep <= cur_tick.start_sweep;
          in_gap = next_gap(in_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  drive_t got;
  drive_t want;
  int     out_stall = 0;
  string  field_name[4] = '{"step_level", "direction", "busy_res", "homed"};

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.step_level, out_ch.direction, out_ch.busy_res, out_ch.homed};
        if (expected_drive.size() == 0) begin
          report_mismatch("result item with no tick pending");
        end else begin
          want = expected_drive.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[3-i] !== want[3-i])
              report_mismatch($sformatf("%s expected %0b got %0b",
                                        field_name[i], want[3-i], got[3-i]));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = next_gap(out_calm);
      end
    end
  end

  task automatic push_tick(input logic sensor, input logic home, input logic sweep);
    tick_queue.push_back({sensor, home, sweep});
    ticks_pushed++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (ticks_taken != ticks_pushed || expected_drive.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_HOME_HALF:   home_half_q = data;
      REG_SWEEP_HALF:  sweep_half_q = data;
      REG_SEEK_GROUP:  seek_group_q = data[GROUP_W-1:0];
      REG_OFFSET:      offset_q = data[PULSE_W-1:0];
      REG_SWEEP_PULSE: sweep_len_q = data[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_half();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return '0;
    if (r < 4)
      return 16'hFFFF;
    if (r < 5)
      return CFG_DATA_W'($urandom_range(5, 300));
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count(input bit allow_top);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return {4'($urandom), 12'd0};
    if (r < 3 && allow_top)
      return {4'($urandom), 12'hFFF};
    return {4'($urandom), 12'($urandom_range(1, 12))};
  endfunction

  initial begin
    int   n;
    int   hold;
    int   phase_no;
    logic lvl;
    in_ch.valid = 1'b0;
    in_ch.home_sensor = 1'b0;
    in_ch.start_home = 1'b0;
    in_ch.start_sweep = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_HOME_HALF;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // idle right after reset
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    drain();

    // empty sweep ignored, zero half period, unused register index
    write_reg(REG_SWEEP_PULSE, '0);
    write_reg(REG_SWEEP_HALF, '0);
    write_reg(REG_UNUSED_BASE + CFG_IDX_W'($urandom_range(0, 2)), 16'hFFFF);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    drain();

    // short sweep, requests while busy are dropped
    write_reg(REG_SWEEP_PULSE, 16'd2);
    push_tick(1'b0, 1'b0, 1'b1);
    repeat (8) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    repeat (3) push_tick(1'b0, 1'b0, 1'b0);
    drain();

    // the single homing run, both requests together on the first item
    write_reg(REG_HOME_HALF, CFG_DATA_W'($urandom_range(0, 3)));
    write_reg(REG_SEEK_GROUP, {12'($urandom), 4'($urandom_range(0, 15))});
    write_reg(REG_OFFSET, {4'($urandom), 12'($urandom_range(0, 1) ? 0 : $urandom_range(1, 12))});
    lvl = 1'($urandom_range(0, 1));
    hold = $urandom_range(3, 60);
    push_tick(lvl, 1'b1, 1'b1);
    for (n = 1; n < 300; n++) begin
      if (n == 150) begin
        drain();
        write_reg(REG_HOME_HALF, CFG_DATA_W'($urandom_range(0, 3)));
        write_reg(REG_OFFSET, {4'($urandom), 12'($urandom_range(0, 12))});
      end
      push_tick((n < hold || $urandom_range(0, 9) == 0) ? lvl : !lvl,
                $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
    end

    // sweep rounds under changing settings
    phase_no = 0;
    while (ticks_pushed < 1400) begin
      drain();
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 0) begin
        write_reg(REG_HOME_HALF, 16'hFFFF);
        write_reg(REG_SWEEP_HALF, 16'd1);
        write_reg(REG_SEEK_GROUP, {12'($urandom), 4'hF});
        write_reg(REG_OFFSET, {4'($urandom), 12'hFFF});
        write_reg(REG_SWEEP_PULSE, {4'($urandom), 12'hFFF});
      end else begin
        if ($urandom_range(0, 1))
          write_reg(REG_HOME_HALF, pick_half());
        if ($urandom_range(0, 1))
          write_reg(REG_SWEEP_HALF, pick_half());
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_SEEK_GROUP, 16'($urandom));
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_OFFSET, pick_count(1'b1));
        if ($urandom_range(0, 1))
          write_reg(REG_SWEEP_PULSE, pick_count(1'b1));
        if ($urandom_range(0, 4) == 0)
          write_reg(REG_UNUSED_BASE + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
      end
      n = $urandom_range(40, 160);
      repeat (n)
        push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                  $urandom_range(0, 9) < 3);
      phase_no++;
    end
    drain();
    repeat (3) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
